FILE: hdl/abae_pkg.sv
// Package with shared types and constants for the adaptive binary arithmetic encoder.
`timescale 1ns / 1ps
`default_nettype none
package abae_pkg;

  localparam int unsigned CountW = 8;
  localparam int unsigned SpaceW = 25;
  localparam int unsigned LowW   = 32;
  localparam int unsigned QuotW  = 8;
  localparam int unsigned DivW   = 16;
  localparam logic [7:0] SplitScale = 8'd175;
  localparam logic [LowW-1:0] LowMask = 32'h00ff_ffff;
  localparam logic [SpaceW-1:0] SpaceReset = 25'd255;
  localparam logic [SpaceW-1:0] RenormLimit = 25'd128;
  localparam logic [4:0] ShiftReset = 5'd24;
  localparam logic [4:0] ShiftByte = 5'd8;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_SETUP,
    ST_DIVIDE,
    ST_APPLY,
    ST_RENORM,
    ST_EMIT,
    ST_FLUSH,
    ST_DRAIN
  } state_e;

  // Request and result of the shared divider.
  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [8:0]      divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

FILE: hdl/abae_ram.sv
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module abae_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Up to one write and one read per cycle, at the same address; the read returns the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

FILE: hdl/abae_divider.sv
// Restoring divider that yields one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module abae_divider (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire abae_pkg::div_req_t req_i,
  output abae_pkg::div_rsp_t      rsp_o
);
  import abae_pkg::*;

  // Dividend is at most 175*256, quotient below 175 fits eight bits.
  logic [DivW-1:0]  rem_q, rem_d;
  logic [QuotW-1:0] quot_q, quot_d;
  logic [8:0]       dsr_q, dsr_d;
  logic [3:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d, done_q, done_d;
  logic [DivW:0]    trial;
  logic [DivW:0]    shifted;

  // One shift and subtract per cycle, quotient bit 7 first.
  always_comb begin
    rem_d   = rem_q;
    quot_d  = quot_q;
    dsr_d   = dsr_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    shifted = {{(DivW-8){1'b0}}, dsr_q} << cnt_q[2:0];
    trial   = {1'b0, rem_q} - shifted;
    if (req_i.start) begin
      rem_d  = req_i.dividend;
      dsr_d  = req_i.divisor;
      quot_d = '0;
      cnt_d  = 4'd7;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[DivW]) begin
        rem_d = trial[DivW-1:0];
      end
      quot_d = {quot_q[QuotW-2:0], ~trial[DivW]};
      if (cnt_q == 4'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dsr_q  <= dsr_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quot_q;

endmodule
`default_nettype wire

FILE: hdl/adaptive_binary_arithmetic_encoder.sv
// Top level of the adaptive binary arithmetic encoder with its sequencer.
// Sequence: after reset a sweep clears all 256 count entries; then per bit a count read,
// divider setup, the quotient, update and renormalize check, with a further renormalize step per doubling.
// A new source word is taken only in idle, once the last one is done; a final word adds four flush words.
// Each coded word is held until the next one shows whether it ends the item; output stalls delay it.
// Reset: counts cleared by a sweep over all 256 entries, range 255, low 0, shift count 24.
`timescale 1ns / 1ps
`default_nettype none
module adaptive_binary_arithmetic_encoder (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] source_byte_i,
  input  wire logic       final_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      coded_byte_o,
  output logic            last_of_run_o
);
  import abae_pkg::*;

  state_e state_q, state_d;

  logic [7:0]        src_q, src_d;
  logic              fin_q, fin_d;
  logic [2:0]        bit_q, bit_d;
  logic [7:0]        node_q, node_d;
  logic [3:0]        coded_q, coded_d;
  logic [SpaceW-1:0] space_q, space_d;
  logic [LowW-1:0]   low_q, low_d;
  logic [4:0]        shift_q, shift_d;
  logic [7:0]        z_q, z_d, o_q, o_d;
  logic [1:0]        fidx_q, fidx_d;
  logic [LowW-1:0]   fval_q, fval_d;
  logic [8:0]        clr_q, clr_d;
  logic [7:0]        ob_q, ob_d;
  logic              ol_q, ol_d, ov_q, ov_d;
  logic              pend_q, pend_d;
  logic [7:0]        hb_q, hb_d;

  logic        ram_we;
  logic [7:0]  ram_addr;
  logic [15:0] ram_wdata, ram_rdata;
  div_req_t    dreq;
  div_rsp_t    drsp;

  abae_ram #(.Width(16), .Depth(256)) u_counts (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  abae_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (dreq),
    .rsp_o  (drsp)
  );

  logic             cur_bit, lps, zmin;
  logic [7:0]       nmin;
  logic [QuotW-1:0] m;
  logic [LowW-1:0]  low_sh;
  logic [SpaceW-1:0] lim;
  logic [2:0]       ks;
  logic [3:0]       svec;
  logic             out_free;

  assign cur_bit  = src_q[bit_q];
  assign zmin     = z_q < o_q;
  assign lps      = ~zmin;
  assign nmin     = (ram_rdata[15:8] < ram_rdata[7:0]) ? ram_rdata[15:8] : ram_rdata[7:0];
  assign m        = (drsp.quotient == '0) ? 8'd1 : drsp.quotient;
  assign low_sh   = {low_q[LowW-2:0], 1'b0};
  assign lim      = SpaceW'(LowMask - {8'd0, low_sh[23:0]});
  assign ks       = shift_q[2:0];
  assign svec     = (ks == 3'd0) ? 4'd8 : {1'b0, ks};
  assign out_free = !ov_q || !out_stall_i;

  // Divider request for the split width, taken from the counts as they are read.
  always_comb begin
    dreq.start    = (state_q == ST_SETUP);
    dreq.dividend = DivW'(SplitScale) * (DivW'(nmin) + 16'd1);
    dreq.divisor  = 9'(ram_rdata[15:8]) + 9'(ram_rdata[7:0]) + 9'd2;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (clr_q == 9'd255) state_d = ST_IDLE;
      ST_IDLE:   if (in_valid_i) state_d = ST_READ;
      ST_READ:   state_d = ST_SETUP;
      ST_SETUP:  state_d = ST_DIVIDE;
      ST_DIVIDE: if (drsp.done) state_d = ST_APPLY;
      ST_APPLY:  state_d = ST_RENORM;
      ST_RENORM: begin
        if (space_q >= RenormLimit) begin
          if (bit_q != 3'd0) state_d = ST_READ;
          else if (fin_q) state_d = ST_FLUSH;
          else state_d = ST_DRAIN;
        end else if (shift_q == 5'd1) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT:   if (out_free || !pend_q || coded_q == 4'd8) state_d = ST_RENORM;
      ST_FLUSH:  if (out_free && !pend_q && fidx_q == 2'd3) state_d = ST_DRAIN;
      ST_DRAIN:  if (out_free || !pend_q) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Datapath and output register.
  always_comb begin
    src_d = src_q; fin_d = fin_q; bit_d = bit_q; node_d = node_q;
    coded_d = coded_q; space_d = space_q; low_d = low_q; shift_d = shift_q;
    z_d = z_q; o_d = o_q; fidx_d = fidx_q; fval_d = fval_q; clr_d = clr_q;
    ob_d = ob_q; ol_d = ol_q; ov_d = ov_q; pend_d = pend_q; hb_d = hb_q;
    ram_we = 1'b0; ram_addr = node_q; ram_wdata = {z_q, o_q};
    in_stall_o = 1'b1;
    if (ov_q && !out_stall_i) ov_d = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1; ram_addr = clr_q[7:0]; ram_wdata = '0;
        clr_d = clr_q + 9'd1;
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          src_d = source_byte_i; fin_d = final_byte_i;
          bit_d = 3'd7; node_d = 8'd1; coded_d = '0; pend_d = 1'b0;
        end
      end
      ST_SETUP: begin
        z_d = ram_rdata[15:8]; o_d = ram_rdata[7:0];
      end
      ST_APPLY: begin
        if (cur_bit == lps) begin
          low_d = low_q + 32'(space_q - 25'(m));
          space_d = 25'(m);
        end else begin
          space_d = space_q - 25'(m);
        end
        if (!cur_bit) begin
          if (z_q == 8'd255) begin z_d = 8'd127; o_d = o_q >> 1; end
          else z_d = z_q + 8'd1;
        end else begin
          if (o_q == 8'd255) begin o_d = 8'd127; z_d = z_q >> 1; end
          else o_d = o_q + 8'd1;
        end
        node_d = {node_q[6:0], cur_bit};
        // Write back the counts of the node just coded.
        ram_we = 1'b1; ram_addr = node_q; ram_wdata = {z_d, o_d};
      end
      ST_RENORM: begin
        if (state_d == ST_READ) bit_d = bit_q - 3'd1;
        if (space_q < RenormLimit && shift_q != 5'd1) begin
          space_d = space_q << 1; low_d = low_sh; shift_d = shift_q - 5'd1;
        end
        fidx_d = '0;
        fval_d = low_q << svec;
      end
      ST_EMIT: begin
        if (coded_q == 4'd8 || !pend_q || out_free) begin
          if (coded_q != 4'd8) begin
            // The held word leaves now that another one follows it.
            if (pend_q) begin
              ov_d = 1'b1; ob_d = hb_q; ol_d = 1'b0;
            end
            hb_d = low_sh[31:24]; pend_d = 1'b1; coded_d = coded_q + 4'd1;
          end
          space_d = ((space_q << 1) > lim) ? lim : (space_q << 1);
          if (space_d == '0) space_d = 25'd1;
          low_d = low_sh & LowMask; shift_d = ShiftByte;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          ov_d = 1'b1;
          if (pend_q) begin
            ob_d = hb_q; ol_d = 1'b0; pend_d = 1'b0;
          end else begin
            ob_d = fval_q[31:24]; ol_d = (fidx_q == 2'd3);
            fval_d = fval_q << 8; fidx_d = fidx_q + 2'd1;
            if (fidx_q == 2'd3) begin
              space_d = SpaceReset; low_d = '0; shift_d = ShiftReset;
            end
          end
        end
      end
      ST_DRAIN: begin
        // The held word is the last coded word of this item.
        if (out_free && pend_q) begin
          ov_d = 1'b1; ob_d = hb_q; ol_d = 1'b1; pend_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR; clr_q <= '0; ov_q <= 1'b0; pend_q <= 1'b0;
      space_q <= SpaceReset; low_q <= '0; shift_q <= ShiftReset;
    end else begin
      state_q <= state_d; clr_q <= clr_d; ov_q <= ov_d; pend_q <= pend_d;
      space_q <= space_d; low_q <= low_d; shift_q <= shift_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q <= src_d; fin_q <= fin_d; bit_q <= bit_d; node_q <= node_d;
    coded_q <= coded_d; z_q <= z_d; o_q <= o_d; fidx_q <= fidx_d;
    fval_q <= fval_d; ob_q <= ob_d; ol_q <= ol_d; hb_q <= hb_d;
  end

  assign out_valid_o   = ov_q;
  assign coded_byte_o  = ob_q;
  assign last_of_run_o = ol_q;

endmodule
`default_nettype wire

FILE: tb/sv/adaptive_binary_arithmetic_encoder_tb.sv
// Testbench for the adaptive binary arithmetic encoder with a built-in coder predictor.
`timescale 1ns / 1ps
module adaptive_binary_arithmetic_encoder_tb;

  typedef struct packed {
    logic [7:0] coded;
    logic       last;
  } coded_word_t;

  // Predicts coded words from source words and checks the block's output against them.
  class coder_scoreboard;
    logic [15:0] node_counts [256];
    logic [31:0] space;
    logic [31:0] low;
    int          shifts;
    coded_word_t pending [$];
    int          errors;

    function void clear_all();
      for (int i = 0; i < 256; i++) node_counts[i] = '0;
      space = 32'd255;
      low = '0;
      shifts = -24;
      errors = 0;
    endfunction

    // Codes one source word and queues the coded words it yields.
    function void note_source(logic [7:0] src, logic fin);
      coded_word_t words [$];
      logic [7:0] node;
      logic [31:0] zc, oc, split, lps, bitv, flushed;
      int produced;
      int k, s;
      coded_word_t w;
      node = 8'd1;
      produced = 0;
      for (int b = 7; b >= 0; b--) begin
        bitv = src[b];
        zc = node_counts[node][15:8];
        oc = node_counts[node][7:0];
        if (zc < oc) begin
          split = (32'd175 * (zc + 1)) / (zc + oc + 2);
          lps = 0;
        end else begin
          split = (32'd175 * (oc + 1)) / (zc + oc + 2);
          lps = 1;
        end
        if (split == 0) split = 1;
        if (bitv == lps) begin
          low = low + space - split;
          space = split;
        end else begin
          space = space - split;
        end
        if (bitv == 0) begin
          if (zc == 255) begin zc = 127; oc = oc >> 1; end else zc++;
        end else begin
          if (oc == 255) begin oc = 127; zc = zc >> 1; end else oc++;
        end
        node_counts[node] = {zc[7:0], oc[7:0]};
        node = {node[6:0], bitv[0]};
        // Renormalize; a word leaves when the shift count reaches zero, first after 24 doublings, then every eight.
        while (space < 128) begin
          space = space << 1;
          low = low << 1;
          shifts++;
          if (shifts == 0) begin
            shifts = -8;
            if (produced < 8) begin
              w.coded = low[31:24];
              w.last = 1'b0;
              words.push_back(w);
              produced++;
            end
            low = low & 32'h00ff_ffff;
            if (32'h00ff_ffff - low < space) space = 32'h00ff_ffff - low;
            if (space == 0) space = 1;
          end
        end
      end
      if (fin) begin
        k = (-shifts) & 255;
        s = (k % 8 != 0) ? k % 8 : 8;
        flushed = low << s;
        for (int i = 3; i >= 0; i--) begin
          w.coded = flushed[8*i +: 8];
          w.last = 1'b0;
          words.push_back(w);
        end
        space = 32'd255;
        low = '0;
        shifts = -24;
      end
      if (words.size() > 0) words[words.size()-1].last = 1'b1;
      foreach (words[i]) pending.push_back(words[i]);
    endfunction

    function void check_word(logic [7:0] coded, logic last);
      coded_word_t exp_w;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word coded=%02h last=%0b", $time, coded, last);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (coded !== exp_w.coded) begin
        $display("%0t: coded_byte expected %02h actual %02h", $time, exp_w.coded, coded);
        errors++;
      end
      if (last !== exp_w.last) begin
        $display("%0t: last_of_run expected %0b actual %0b", $time, exp_w.last, last);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] source_byte_i;
  logic       final_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] coded_byte_o;
  logic       last_of_run_o;

  coder_scoreboard coder_sb;
  bit   quiet_phase;
  bit   hold_receiver;
  int   idle_cycles;

  adaptive_binary_arithmetic_encoder dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .source_byte_i(source_byte_i), .final_byte_i(final_byte_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .coded_byte_o(coded_byte_o), .last_of_run_o(last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Offers one source word and waits until it is accepted.
  task automatic send_source(logic [7:0] src, logic fin);
    int gap;
    if (!quiet_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    source_byte_i = src;
    final_byte_i = fin;
    do @(posedge clk_i); while (in_stall_o);
    coder_sb.note_source(src, fin);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // Receiver: random stall bursts, or one long hold-off on request.
  initial begin
    int burst;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_receiver) begin
        out_stall_i <= 1'b1;
        repeat (2500) @(negedge clk_i);
        hold_receiver = 1'b0;
        out_stall_i <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(1, 6);
        out_stall_i <= 1'b1;
        repeat (burst) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // Checks coded words on accepting edges and watches for a stuck handshake.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) coder_sb.check_word(coded_byte_o, last_of_run_o);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] src;
    int drain;
    coder_sb = new();
    coder_sb.clear_all();
    quiet_phase = 1'b0;
    hold_receiver = 1'b0;
    idle_cycles = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    source_byte_i = '0;
    final_byte_i = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extremes, repeated words to skew counts, flushes.
    send_source(8'h00, 1'b0);
    send_source(8'hff, 1'b0);
    send_source(8'h55, 1'b0);
    send_source(8'haa, 1'b1);
    send_source(8'h80, 1'b1);
    send_source(8'h01, 1'b0);
    for (int i = 0; i < 14; i++) send_source(8'h00, i == 13);
    send_source(8'hff, 1'b1);

    // Long receiver hold-off while the sender keeps offering.
    hold_receiver = 1'b1;
    for (int i = 0; i < 20; i++) send_source(8'($urandom), 1'b0);

    // Random part: skewed symbols so counts grow, occasional stream ends.
    for (int i = 0; i < 110; i++) begin
      if (i == 85) quiet_phase = 1'b1;
      case ($urandom_range(0, 2))
        0: src = 8'($urandom);
        1: src = 8'($urandom_range(0, 3));
        default: src = 8'hf0 | 8'($urandom_range(0, 15));
      endcase
      send_source(src, $urandom_range(0, 9) == 0 || i == 109);
    end

    // Wait for every expected word, then some settling cycles.
    drain = 0;
    while (coder_sb.pending.size() != 0 && drain < 200000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (400) @(posedge clk_i);
    if (coder_sb.errors == 0 && coder_sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/abae_pkg.sv
hdl/abae_ram.sv
hdl/abae_divider.sv
hdl/adaptive_binary_arithmetic_encoder.sv
tb/sv/adaptive_binary_arithmetic_encoder_tb.sv
